[design/ptlik_pkg.sv]
// Shared constants, tables and types for the planar three-link IK unit.
package ptlik_pkg;

  localparam int FRAC_BITS = 16;
  localparam int QB        = 30;
  localparam int ANG_W     = 20;
  localparam int LEN_W     = 18;
  localparam int CFG_IDX_W = 2;
  localparam int CW        = 48;
  localparam int ZW        = 36;
  localparam int AW        = 52;
  localparam int SW        = 22;
  localparam int CQ_W      = 32;
  localparam int STEPS     = 30;
  localparam int NORM_R    = 10;
  localparam int NORM_L    = 6;
  localparam int NORM_HI   = 41;
  localparam int DIV_STEPS = 31;
  localparam int DREM_W    = 40;
  localparam int DEN_W     = 37;
  localparam int SQ_W      = 62;
  localparam int SQ_STEPS  = 31;
  localparam int ATAN_LAT  = 1 + NORM_R + NORM_L + STEPS;

  localparam logic signed [ZW-1:0] PI_Q30      = 36'sd3373259426;
  localparam logic signed [ZW-1:0] HALF_PI_Q30 = 36'sd1686629713;
  localparam logic signed [ZW-1:0] TWO_PI_Q30  = 36'sd6746518853;
  localparam logic signed [CW-1:0] GAIN_Q30    = 48'sd652032874;

  localparam logic [31:0] ATAN_TAB [STEPS] = '{
    32'd843314857, 32'd497837830, 32'd263043837, 32'd133525159, 32'd67021687,
    32'd33543516,  32'd16775851,  32'd8388437,   32'd4194283,   32'd2097149,
    32'd1048576,   32'd524288,    32'd262144,    32'd131072,    32'd65536,
    32'd32768,     32'd16384,     32'd8192,      32'd4096,      32'd2048,
    32'd1024,      32'd512,       32'd256,       32'd128,       32'd64,
    32'd32,        32'd16,        32'd8,         32'd4,         32'd2
  };

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_UPPER = 2'd0,
    REG_LOWER = 2'd1,
    REG_TIP   = 2'd2
  } cfg_reg_t;

  // Sideband carried alongside each word through the pipe
  typedef struct packed {
    logic signed [ANG_W-1:0] tx;
    logic signed [ANG_W-1:0] ty;
    logic signed [ANG_W-1:0] th;
    logic                    tag;
    logic                    sneg;
    logic                    nneg;
    logic                    unr;
    logic signed [SW-1:0]    s;
    logic signed [SW-1:0]    r;
    logic signed [CQ_W-1:0]  cq;
  } side_t;

endpackage

[design/ptlik_cordic_cell.sv]
// One CORDIC micro-rotation cell, rotation or vectoring, registered.
module ptlik_cordic_cell #(
  parameter int SHIFT = 0,
  parameter bit VECT  = 1'b0
) (
  input  logic                            clk,
  input  logic                            en,
  input  logic signed [ptlik_pkg::CW-1:0] x,
  input  logic signed [ptlik_pkg::CW-1:0] y,
  input  logic signed [ptlik_pkg::ZW-1:0] z,
  output logic signed [ptlik_pkg::CW-1:0] xr,
  output logic signed [ptlik_pkg::CW-1:0] yr,
  output logic signed [ptlik_pkg::ZW-1:0] zr
);
  import ptlik_pkg::*;

  localparam logic signed [ZW-1:0] STEP_ANG =
    $signed({{(ZW-32){1'b0}}, ATAN_TAB[SHIFT]});

  logic                 up;
  logic signed [CW-1:0] xs;
  logic signed [CW-1:0] ys;

  // Pick direction: angle sign when rotating, y sign when vectoring
  assign up = VECT ? y[CW-1] : ~z[ZW-1];
  assign xs = x >>> SHIFT;
  assign ys = y >>> SHIFT;

  // Advance one micro-rotation
  always_ff @(posedge clk) begin
    if (en) begin
      if (up) begin
        xr <= x - ys;
        yr <= y + xs;
        zr <= z - STEP_ANG;
      end else begin
        xr <= x + ys;
        yr <= y - xs;
        zr <= z + STEP_ANG;
      end
    end
  end

endmodule

[design/ptlik_div_cell.sv]
// One restoring-division step cell, one quotient bit per cell.
module ptlik_div_cell (
  input  logic                               clk,
  input  logic                               en,
  input  logic [ptlik_pkg::DREM_W-1:0]       rem,
  input  logic [ptlik_pkg::DIV_STEPS-1:0]    quo,
  input  logic [ptlik_pkg::DEN_W-1:0]        den,
  output logic [ptlik_pkg::DREM_W-1:0]       remr,
  output logic [ptlik_pkg::DIV_STEPS-1:0]    quor
);
  import ptlik_pkg::*;

  logic [DREM_W-1:0] den_ext;
  logic              ge;
  logic [DREM_W-1:0] diff;

  assign den_ext = {{(DREM_W-DEN_W){1'b0}}, den};
  assign ge      = rem >= den_ext;
  assign diff    = ge ? rem - den_ext : rem;

  // Shift in the quotient bit and the partial remainder
  always_ff @(posedge clk) begin
    if (en) begin
      remr <= diff << 1;
      quor <= {quo[DIV_STEPS-2:0], ge};
    end
  end

endmodule

[design/ptlik_sqrt_cell.sv]
// One digit-by-digit square-root cell, one result bit per cell.
module ptlik_sqrt_cell #(
  parameter int K = 0
) (
  input  logic                          clk,
  input  logic                          en,
  input  logic [ptlik_pkg::SQ_W-1:0]    v,
  input  logic [ptlik_pkg::SQ_W-1:0]    res,
  output logic [ptlik_pkg::SQ_W-1:0]    vr,
  output logic [ptlik_pkg::SQ_W-1:0]    resr
);
  import ptlik_pkg::*;

  localparam logic [SQ_W-1:0] BITV = {{(SQ_W-1){1'b0}}, 1'b1} << (2 * K);

  logic [SQ_W-1:0] t;
  logic            ge;

  assign t  = res + BITV;
  assign ge = v >= t;

  // Try the bit, keep it when the remainder allows
  always_ff @(posedge clk) begin
    if (en) begin
      if (ge) begin
        vr   <= v - t;
        resr <= (res >> 1) + BITV;
      end else begin
        vr   <= v;
        resr <= res >> 1;
      end
    end
  end

endmodule

[design/ptlik_atan2.sv]
// Pipelined atan2: quadrant fold, operand normalise, vectoring CORDIC row.
module ptlik_atan2 (
  input  logic                            clk,
  input  logic                            en,
  input  logic signed [ptlik_pkg::AW-1:0] y,
  input  logic signed [ptlik_pkg::AW-1:0] x,
  output logic signed [ptlik_pkg::ZW-1:0] z
);
  import ptlik_pkg::*;

  localparam int NN = NORM_R + NORM_L;

  logic signed [AW-1:0] nx [0:NN];
  logic signed [AW-1:0] ny [0:NN];
  logic signed [ZW-1:0] zd [0:NN];
  logic                 zf [0:ATAN_LAT-1];

  logic signed [CW-1:0] cx [0:STEPS];
  logic signed [CW-1:0] cy [0:STEPS];
  logic signed [ZW-1:0] cz [0:STEPS];

  function automatic logic [AW-1:0] mag(input logic signed [AW-1:0] v);
    mag = v[AW-1] ? $unsigned(-v) : $unsigned(v);
  endfunction

  // Fold the left half plane, then scale the operand pair so the larger magnitude lies in [2^40, 2^41)
  always_ff @(posedge clk) begin
    if (en) begin
      zf[0] <= (x == '0) && (y == '0);
      if (x[AW-1]) begin
        zd[0] <= y[AW-1] ? -PI_Q30 : PI_Q30;
        nx[0] <= -x;
        ny[0] <= -y;
      end else begin
        zd[0] <= '0;
        nx[0] <= x;
        ny[0] <= y;
      end
      for (int i = 0; i < NORM_R; i++) begin
        zd[i+1] <= zd[i];
        if (mag(nx[i]) >= (AW'(1) << NORM_HI) || mag(ny[i]) >= (AW'(1) << NORM_HI)) begin
          nx[i+1] <= nx[i] >>> 1;
          ny[i+1] <= ny[i] >>> 1;
        end else begin
          nx[i+1] <= nx[i];
          ny[i+1] <= ny[i];
        end
      end
      for (int j = 0; j < NORM_L; j++) begin
        zd[NORM_R+j+1] <= zd[NORM_R+j];
        if ((mag(nx[NORM_R+j]) | mag(ny[NORM_R+j])) <
            (AW'(1) << (NORM_HI - (1 << (NORM_L - 1 - j))))) begin
          nx[NORM_R+j+1] <= nx[NORM_R+j] <<< (1 << (NORM_L - 1 - j));
          ny[NORM_R+j+1] <= ny[NORM_R+j] <<< (1 << (NORM_L - 1 - j));
        end else begin
          nx[NORM_R+j+1] <= nx[NORM_R+j];
          ny[NORM_R+j+1] <= ny[NORM_R+j];
        end
      end
      for (int k = 1; k < ATAN_LAT; k++) begin
        zf[k] <= zf[k-1];
      end
    end
  end

  assign cx[0] = CW'(nx[NN]);
  assign cy[0] = CW'(ny[NN]);
  assign cz[0] = zd[NN];

  // Row of vectoring cells
  for (genvar g = 0; g < STEPS; g++) begin : g_cell
    ptlik_cordic_cell #(.SHIFT(g), .VECT(1'b1)) u_cell (
      .clk (clk),
      .en  (en),
      .x   (cx[g]),
      .y   (cy[g]),
      .z   (cz[g]),
      .xr  (cx[g+1]),
      .yr  (cy[g+1]),
      .zr  (cz[g+1])
    );
  end

  // Both operands zero gives angle zero
  assign z = zf[ATAN_LAT-1] ? '0 : cz[STEPS];

endmodule

[design/planar_three_link_ik_unit.sv]
// Top level: planar three-link inverse kinematics, elbow-down, as a row of cells.
// Throughput: one pose per cycle while the output is not held; every loop is a row of cells advancing together.
// A stalled output freezes the row; an empty first stage still takes a word.
// Reset clears the valid bits and the link-length registers; data is not reset.
module planar_three_link_ik_unit (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   cfg_we,
  input  logic [ptlik_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [ptlik_pkg::LEN_W-1:0]            cfg_data,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  logic signed [ptlik_pkg::ANG_W-1:0]     target_x,
  input  logic signed [ptlik_pkg::ANG_W-1:0]     target_y,
  input  logic signed [ptlik_pkg::ANG_W-1:0]     target_angle,
  input  logic                                   leg_tag,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic signed [ptlik_pkg::ANG_W-1:0]     shoulder_angle,
  output logic signed [ptlik_pkg::ANG_W-1:0]     elbow_angle,
  output logic signed [ptlik_pkg::ANG_W-1:0]     wrist_angle,
  output logic                                   unreachable,
  output logic                                   leg_tag_out
);
  import ptlik_pkg::*;

  localparam int ST_RED  = 1;
  localparam int ST_MUL3 = ST_RED + STEPS + 1;
  localparam int ST_WP   = ST_MUL3 + 1;
  localparam int ST_SQ   = ST_WP + 1;
  localparam int ST_NUM  = ST_SQ + 1;
  localparam int ST_QQ   = ST_NUM + DIV_STEPS;
  localparam int ST_SQV  = ST_QQ + 1;
  localparam int ST_PROD = ST_SQV + SQ_STEPS + 1;
  localparam int ST_OPS  = ST_PROD + 1;
  localparam int ST_ANG  = ST_OPS + ATAN_LAT + 1;
  localparam int ST_OUT  = ST_ANG + 1;
  localparam int NST     = ST_OUT + 1;
  localparam int TSH     = QB - FRAC_BITS;
  localparam int OW      = 40;

  // Link lengths and derived constants
  logic [LEN_W-1:0]   l1, l2, l3;
  logic [2*LEN_W-1:0] l1sq, l2sq;
  logic [DEN_W-1:0]   den;

  logic           en, load0;
  logic [NST-1:0] vld;
  side_t          side   [0:NST-1];
  side_t          side_d [0:NST-1];

  // Stage data
  logic signed [ZW-1:0]   red_a, red_b, red_c, red_z;
  logic                   red_neg;
  logic signed [ZW-1:0]   rot_z0;
  logic signed [CW-1:0]   rx [0:STEPS];
  logic signed [CW-1:0]   ry [0:STEPS];
  logic signed [ZW-1:0]   rz [0:STEPS];
  logic signed [CW-1:0]   cos_w, sin_w;
  logic signed [50:0]     pc, ps;
  logic signed [50:0]     pcr, psr, s_full, r_full;
  logic signed [2*SW-1:0] ss, rr;
  logic signed [45:0]     num, den_s;
  logic [DREM_W-1:0]      rem0;
  logic [DREM_W-1:0]      drem [0:DIV_STEPS];
  logic [DIV_STEPS-1:0]   dq   [0:DIV_STEPS];
  logic [DIV_STEPS-1:0]   quo;
  logic [SQ_W-1:0]        qq, sqv;
  logic [SQ_W-1:0]        sv [0:SQ_STEPS];
  logic [SQ_W-1:0]        sr [0:SQ_STEPS];
  logic [DIV_STEPS-1:0]   sn_r;
  logic [48:0]            p_ys;
  logic signed [50:0]     p_xc;
  logic signed [AW-1:0]   el_y, el_x, ph_y, ph_x, bs_y, bs_x;
  logic signed [ZW-1:0]   el_z, ph_z, bs_z;
  logic signed [ZW:0]     sh_a;
  logic signed [ZW-1:0]   el_a;
  logic signed [ZW+1:0]   wr_a, th_w;

  function automatic logic signed [ANG_W-1:0] to_out(input logic signed [ZW+1:0] a);
    logic signed [OW-1:0] v;
    v = (OW'(a) + (OW'(1) <<< (TSH - 1))) >>> TSH;
    if (v > OW'((1 << (ANG_W - 1)) - 1)) begin
      to_out = {1'b0, {(ANG_W-1){1'b1}}};
    end else if (v < -OW'(1 << (ANG_W - 1))) begin
      to_out = {1'b1, {(ANG_W-1){1'b0}}};
    end else begin
      to_out = ANG_W'(v);
    end
  endfunction

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      l1 <= '0;
      l2 <= '0;
      l3 <= '0;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_UPPER: l1 <= cfg_data;
        REG_LOWER: l2 <= cfg_data;
        REG_TIP:   l3 <= cfg_data;
        default: ;
      endcase
    end
  end

  // Constants that follow the link lengths
  always_ff @(posedge clk) begin
    l1sq <= l1 * l1;
    l2sq <= l2 * l2;
    den  <= {(2*LEN_W)'(l1) * (2*LEN_W)'(l2), 1'b0};
  end

  // Handshake: the row advances unless the output word is held
  assign en        = ~vld[NST-1] | out_ready;
  assign load0     = en | ~vld[0];
  assign in_ready  = load0;
  assign out_valid = vld[NST-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (load0) begin
        vld[0] <= in_valid;
      end
      if (en) begin
        vld[NST-1:1] <= vld[NST-2:0];
      end
    end
  end

  // Angle reduction into [-pi/2, pi/2] with a sign flag
  always_comb begin
    red_a = (ZW'(side[0].th) <<< TSH) + PI_Q30;
    if (red_a >= TWO_PI_Q30) begin
      red_b = red_a - TWO_PI_Q30;
    end else if (red_a < 0) begin
      red_b = red_a + TWO_PI_Q30;
    end else begin
      red_b = red_a;
    end
    red_c = red_b - PI_Q30;
    if (red_c > HALF_PI_Q30) begin
      red_z   = red_c - PI_Q30;
      red_neg = 1'b1;
    end else if (red_c < -HALF_PI_Q30) begin
      red_z   = red_c + PI_Q30;
      red_neg = 1'b1;
    end else begin
      red_z   = red_c;
      red_neg = 1'b0;
    end
  end

  // Wrist point, law-of-cosines numerator, divider input and wrist angle
  always_comb begin
    pcr    = (pc + (51'sd1 <<< (QB - 1))) >>> QB;
    psr    = (ps + (51'sd1 <<< (QB - 1))) >>> QB;
    s_full = 51'(side[ST_MUL3].tx) - pcr;
    r_full = 51'(side[ST_MUL3].ty) - psr;
    num    = 46'(ss) + 46'(rr) - $signed({10'b0, l1sq}) - $signed({10'b0, l2sq});
    den_s  = $signed({9'b0, den});
    rem0   = num[45] ? DREM_W'($unsigned(-num)) : DREM_W'($unsigned(num));
    quo    = dq[DIV_STEPS];
    th_w   = (ZW+2)'(side[ST_ANG].th) <<< TSH;
    wr_a   = th_w - (ZW+2)'(sh_a) - (ZW+2)'(el_a);
  end

  // Sideband: shift along, overwrite where a stage produces a field
  always_comb begin
    side_d[0].tx   = target_x;
    side_d[0].ty   = target_y;
    side_d[0].th   = target_angle;
    side_d[0].tag  = leg_tag;
    side_d[0].sneg = 1'b0;
    side_d[0].nneg = 1'b0;
    side_d[0].unr  = 1'b0;
    side_d[0].s    = '0;
    side_d[0].r    = '0;
    side_d[0].cq   = '0;
    for (int i = 1; i < NST; i++) begin
      side_d[i] = side[i-1];
    end
    side_d[ST_RED].sneg = red_neg;
    side_d[ST_WP].s     = SW'(s_full);
    side_d[ST_WP].r     = SW'(r_full);
    side_d[ST_NUM].unr  = (den == '0) || (num > den_s) || (num < -den_s);
    side_d[ST_NUM].nneg = num[45];
    side_d[ST_QQ].cq    = side[ST_QQ-1].nneg ? -$signed({1'b0, quo}) : $signed({1'b0, quo});
  end

  always_ff @(posedge clk) begin
    if (load0) begin
      side[0] <= side_d[0];
    end
    if (en) begin
      for (int i = 1; i < NST; i++) begin
        side[i] <= side_d[i];
      end
    end
  end

  // Sine and cosine row
  assign rx[0] = GAIN_Q30;
  assign ry[0] = '0;
  assign rz[0] = rot_z0;

  for (genvar g = 0; g < STEPS; g++) begin : g_rot
    ptlik_cordic_cell #(.SHIFT(g), .VECT(1'b0)) u_rot (
      .clk (clk),
      .en  (en),
      .x   (rx[g]),
      .y   (ry[g]),
      .z   (rz[g]),
      .xr  (rx[g+1]),
      .yr  (ry[g+1]),
      .zr  (rz[g+1])
    );
  end

  assign cos_w = side[ST_MUL3-1].sneg ? -rx[STEPS] : rx[STEPS];
  assign sin_w = side[ST_MUL3-1].sneg ? -ry[STEPS] : ry[STEPS];

  // Division row for the elbow cosine
  assign drem[0] = rem0;
  assign dq[0]   = '0;

  for (genvar g = 0; g < DIV_STEPS; g++) begin : g_div
    ptlik_div_cell u_div (
      .clk  (clk),
      .en   (en),
      .rem  (drem[g]),
      .quo  (dq[g]),
      .den  (den),
      .remr (drem[g+1]),
      .quor (dq[g+1])
    );
  end

  // Square-root row for the elbow sine
  assign sv[0] = sqv;
  assign sr[0] = '0;

  for (genvar g = 0; g < SQ_STEPS; g++) begin : g_sqrt
    ptlik_sqrt_cell #(.K(SQ_STEPS - 1 - g)) u_sqrt (
      .clk  (clk),
      .en   (en),
      .v    (sv[g]),
      .res  (sr[g]),
      .vr   (sv[g+1]),
      .resr (sr[g+1])
    );
  end

  // Three atan2 rows in lockstep
  ptlik_atan2 u_elbow (.clk(clk), .en(en), .y(el_y), .x(el_x), .z(el_z));
  ptlik_atan2 u_phi   (.clk(clk), .en(en), .y(ph_y), .x(ph_x), .z(ph_z));
  ptlik_atan2 u_base  (.clk(clk), .en(en), .y(bs_y), .x(bs_x), .z(bs_z));

  // Stage registers between the rows
  always_ff @(posedge clk) begin
    if (en) begin
      rot_z0 <= red_z;
      pc     <= $signed({1'b0, l3}) * $signed(cos_w[CQ_W-1:0]);
      ps     <= $signed({1'b0, l3}) * $signed(sin_w[CQ_W-1:0]);
      ss     <= side[ST_WP].s * side[ST_WP].s;
      rr     <= side[ST_WP].r * side[ST_WP].r;
      qq     <= SQ_W'(quo) * SQ_W'(quo);
      sqv    <= ({{(SQ_W-1){1'b0}}, 1'b1} << (2 * QB)) - qq;
      sn_r   <= sr[SQ_STEPS][DIV_STEPS-1:0];
      p_ys   <= l2 * sr[SQ_STEPS][DIV_STEPS-1:0];
      p_xc   <= $signed({1'b0, l2}) * side[ST_PROD-1].cq;
      el_y   <= $signed({{(AW-DIV_STEPS){1'b0}}, sn_r});
      el_x   <= AW'(side[ST_PROD].cq);
      ph_y   <= $signed({{(AW-49){1'b0}}, p_ys});
      ph_x   <= $signed({{(AW-LEN_W-QB){1'b0}}, l1, {QB{1'b0}}}) + AW'(p_xc);
      bs_y   <= AW'(side[ST_PROD].r);
      bs_x   <= AW'(side[ST_PROD].s);
      sh_a   <= (ZW+1)'(bs_z) - (ZW+1)'(ph_z);
      el_a   <= el_z;
      if (side[ST_ANG].unr) begin
        shoulder_angle <= '0;
        elbow_angle    <= '0;
        wrist_angle    <= '0;
      end else begin
        shoulder_angle <= to_out((ZW+2)'(sh_a));
        elbow_angle    <= to_out((ZW+2)'(el_a));
        wrist_angle    <= to_out(wr_a);
      end
    end
  end

  assign unreachable = side[NST-1].unr;
  assign leg_tag_out = side[NST-1].tag;

  // Checks
  a_zero_link: assert property (@(posedge clk) disable iff (rst)
    (vld[ST_NUM] && den == '0) |-> side[ST_NUM].unr)
    else $error("zero link length not flagged unreachable");

  a_cos_range: assert property (@(posedge clk) disable iff (rst)
    (vld[ST_QQ] && !side[ST_QQ].unr) |-> (qq <= ({{(SQ_W-1){1'b0}}, 1'b1} << (2 * QB))))
    else $error("elbow cosine above one on a reachable pose");

  a_sin_range: assert property (@(posedge clk) disable iff (rst)
    (vld[ST_PROD] && !side[ST_PROD].unr) |-> (sn_r <= (DIV_STEPS'(1) << QB)))
    else $error("elbow sine above one on a reachable pose");

  a_unr_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && unreachable) |->
      (shoulder_angle == '0 && elbow_angle == '0 && wrist_angle == '0))
    else $error("unreachable word carries non-zero angles");

endmodule
